### rtl/core/rpt_pkg.sv
// Shared types, constants and codes for the retransmit pending table.
package rpt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int TOKEN_BYTES   = 8;
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_REMALL = 3'd2;
    localparam logic [2:0] OP_LOOKUP = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [3:0] KIND_ADDED    = 4'd0;
    localparam logic [3:0] KIND_DUP      = 4'd1;
    localparam logic [3:0] KIND_FULL     = 4'd2;
    localparam logic [3:0] KIND_REMOVED  = 4'd3;
    localparam logic [3:0] KIND_NOTFOUND = 4'd4;
    localparam logic [3:0] KIND_FOUND    = 4'd5;
    localparam logic [3:0] KIND_RESEND   = 4'd6;
    localparam logic [3:0] KIND_EXPIRED  = 4'd7;
    localparam logic [3:0] KIND_DONE     = 4'd8;

    localparam logic [0:0] CFG_LIMIT   = 1'd0;
    localparam logic [0:0] CFG_TIMEOUT = 1'd1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] id;
        logic [3:0]  len;
        logic [63:0] tok;
        logic [15:0] link;
        logic [15:0] buffer;
        logic        mcast;
    } rpt_item_t;

    typedef struct packed {
        logic [15:0] id;
        logic [63:0] tok;
        logic [3:0]  len;
        logic [15:0] link;
        logic [15:0] buffer;
        logic [7:0]  attempts;
        logic [7:0]  limit;
        logic [15:0] timer;
    } rpt_entry_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] id;
        logic [15:0] link;
        logic [15:0] buffer;
        logic [4:0]  count;
        logic        last;
    } rpt_result_t;

    typedef struct packed {
        logic       push;
        logic       full;
    } rpt_qctl_t;

endpackage

### rtl/core/rpt_queue.sv
// Short item queue between the front and the back of the table unit.
module rpt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rpt_pkg::rpt_item_t push_item,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output rpt_pkg::rpt_item_t pop_item
);
    import rpt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    rpt_item_t          q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    assign full      = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_item  = q_reg[rd_reg];

    always_comb
    begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/rpt_front.sv
// Front end: accepts input items and normalizes the token before queuing.
module rpt_front (
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic [15:0]        message_id,
    input  logic [3:0]         token_length,
    input  logic [63:0]        token_value,
    input  logic [15:0]        link_handle,
    input  logic [15:0]        buffer_handle,
    input  logic               is_multicast,
    input  logic               q_full,
    output rpt_pkg::rpt_qctl_t qctl,
    output rpt_pkg::rpt_item_t item
);
    import rpt_pkg::*;

    logic [3:0] len_c;

    assign in_stall  = q_full;
    assign qctl.push = in_valid && !q_full;
    assign qctl.full = q_full;
    assign len_c = (token_length > 4'(TOKEN_BYTES)) ? 4'(TOKEN_BYTES) : token_length;

    always_comb
    begin
        item.opcode = opcode;
        item.id     = message_id;
        item.len    = len_c;
        item.link   = link_handle;
        item.buffer = buffer_handle;
        item.mcast  = is_multicast;
        // Bytes beyond the token length never take part in a match.
        for (int b = 0; b < 8; b++)
        begin
            item.tok[b*8 +: 8] = (4'(b) < len_c) ? token_value[b*8 +: 8] : 8'h00;
        end
    end

endmodule

### rtl/core/rpt_back.sv
// Back end: holds the table, walks it one entry per cycle while the result output is not stalled, and emits results.
module rpt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          cfg_limit,
    input  logic [15:0]         cfg_timeout,
    input  logic                q_not_empty,
    input  rpt_pkg::rpt_item_t  q_item,
    output logic                q_pop,
    input  logic                out_stall,
    output logic                out_valid,
    output rpt_pkg::rpt_result_t res
);
    import rpt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    rpt_entry_t   table_reg [TABLE_ENTRIES];
    rpt_entry_t   table_next [TABLE_ENTRIES];
    logic [1:0]   state_reg, state_next;
    rpt_item_t    cur_reg, cur_next;
    logic [CNT_W-1:0] idx_reg, idx_next, count_reg, count_next;
    logic [4:0]   rm_reg, rm_next;
    logic         out_valid_reg, out_valid_next;
    rpt_result_t  res_reg, res_next;

    rpt_entry_t   e;
    logic         out_ok, tok_hit, full_hit, drop;

    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign out_ok    = !out_valid_reg || !out_stall;
    assign e         = table_reg[idx_reg[IDX_W-1:0]];
    assign tok_hit   = (e.len == cur_reg.len) && (e.tok == cur_reg.tok);
    assign full_hit  = tok_hit && (e.id == cur_reg.id);

    always_comb
    begin
        table_next     = table_reg;
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        rm_next        = rm_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_next       = res_reg;
        q_pop          = 1'b0;
        drop           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    idx_next = '0;
                    rm_next  = '0;
                    if (q_item.opcode == OP_CLEAR)
                    begin
                        count_next = '0;
                        state_next = ST_DONE;
                    end
                    else if (q_item.opcode <= OP_TICK)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (out_ok)
                begin
                    res_next = '{kind: KIND_DONE, id: e.id, link: e.link, buffer: e.buffer,
                                 count: 5'd0, last: 1'b0};
                    if (idx_reg == count_reg)
                    begin
                        state_next = ST_END;
                    end
                    else if (cur_reg.opcode == OP_REMALL)
                    begin
                        if (tok_hit)
                        begin
                            res_next.kind  = KIND_REMOVED;
                            out_valid_next = 1'b1;
                            drop           = 1'b1;
                            if (rm_reg != 5'h1F)
                            begin
                                rm_next = rm_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    else if (cur_reg.opcode == OP_TICK)
                    begin
                        if (e.timer != 16'd0)
                        begin
                            table_next[idx_reg[IDX_W-1:0]].timer = e.timer - 1'b1;
                            idx_next = idx_reg + 1'b1;
                        end
                        else if (e.attempts < e.limit)
                        begin
                            table_next[idx_reg[IDX_W-1:0]].timer    = cfg_timeout;
                            table_next[idx_reg[IDX_W-1:0]].attempts = e.attempts + 1'b1;
                            res_next.kind  = KIND_RESEND;
                            out_valid_next = 1'b1;
                            idx_next       = idx_reg + 1'b1;
                        end
                        else
                        begin
                            res_next.kind  = KIND_EXPIRED;
                            out_valid_next = 1'b1;
                            drop           = 1'b1;
                        end
                    end
                    else
                    begin
                        // Add, remove and lookup stop at the first full match.
                        if (full_hit)
                        begin
                            out_valid_next = 1'b1;
                            state_next     = ST_DONE;
                            if (cur_reg.opcode == OP_ADD)
                            begin
                                res_next.kind = KIND_DUP;
                            end
                            else if (cur_reg.opcode == OP_REMOVE)
                            begin
                                res_next.kind = KIND_REMOVED;
                                drop          = 1'b1;
                            end
                            else
                            begin
                                res_next.kind = KIND_FOUND;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
            end
            ST_END:
            begin
                if (out_ok)
                begin
                    state_next = ST_DONE;
                    res_next = '{kind: KIND_NOTFOUND, id: cur_reg.id, link: 16'd0,
                                 buffer: 16'd0, count: 5'd0, last: 1'b0};
                    if (cur_reg.opcode == OP_ADD)
                    begin
                        res_next.link   = cur_reg.link;
                        res_next.buffer = cur_reg.buffer;
                        out_valid_next  = 1'b1;
                        if (count_reg == CNT_W'(TABLE_ENTRIES))
                        begin
                            res_next.kind = KIND_FULL;
                        end
                        else
                        begin
                            res_next.kind = KIND_ADDED;
                            table_next[count_reg[IDX_W-1:0]] = '{
                                id: cur_reg.id, tok: cur_reg.tok, len: cur_reg.len,
                                link: cur_reg.link, buffer: cur_reg.buffer,
                                attempts: 8'd1, limit: cur_reg.mcast ? 8'd1 : cfg_limit,
                                timer: cfg_timeout};
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (cur_reg.opcode == OP_REMOVE || cur_reg.opcode == OP_LOOKUP)
                    begin
                        out_valid_next = 1'b1;
                    end
                    else if (cur_reg.opcode == OP_REMALL && rm_reg == 5'd0)
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_ok)
                begin
                    res_next = '{kind: KIND_DONE, id: 16'd0, link: 16'd0, buffer: 16'd0,
                                 count: (cur_reg.opcode == OP_REMALL) ? rm_reg : 5'd0,
                                 last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Closing the gap: every entry at or above the dropped one takes its upper neighbor.
        if (drop)
        begin
            for (int j = 0; j < TABLE_ENTRIES - 1; j++)
            begin
                if (CNT_W'(j) >= idx_reg)
                begin
                    table_next[j] = table_reg[j + 1];
                end
            end
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            rm_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            rm_reg        <= rm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        table_reg <= table_next;
        cur_reg   <= cur_next;
        res_reg   <= res_next;
    end

endmodule

### rtl/core/retransmit_pending_table_unit.sv
// Top level of the retransmit pending table: front end, item queue and back end.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   input    | in_valid / in_stall  | opcode, message_id, token_*, link, buffer, mc
//   result   | out_valid / out_stall| kind, out_message_id, out_link, out_buffer,
//            |                      | removed_count, last
//   config   | cfg_we               | cfg_index, cfg_data
//
// The back end walks the table one entry per cycle while results are not
// stalled, so the time an item takes grows with the number of stored entries
// and with stalled results; a full table holds 16 entries.
// Reset clears the entry count, the queue and the output valid; no clearing pass.
// A two-deep queue lets the front keep taking items while the back waits on
// out_stall; in_stall rises only once that queue is full.
module retransmit_pending_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [15:0] message_id,
    input  logic [3:0]  token_length,
    input  logic [63:0] token_value,
    input  logic [15:0] link_handle,
    input  logic [15:0] buffer_handle,
    input  logic        is_multicast,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  kind,
    output logic [15:0] out_message_id,
    output logic [15:0] out_link,
    output logic [15:0] out_buffer,
    output logic [4:0]  removed_count,
    output logic        last,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rpt_pkg::*;

    logic [7:0]  limit_reg;
    logic [15:0] timeout_reg;
    rpt_qctl_t   qctl;
    rpt_item_t   f_item, q_item;
    logic        q_full, q_not_empty, q_pop;
    rpt_result_t res;

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= 8'd4;
            timeout_reg <= 16'd2000;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_LIMIT)
            begin
                limit_reg <= cfg_data[7:0];
            end
            else if (cfg_index == CFG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    rpt_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .message_id    (message_id),
        .token_length  (token_length),
        .token_value   (token_value),
        .link_handle   (link_handle),
        .buffer_handle (buffer_handle),
        .is_multicast  (is_multicast),
        .q_full        (q_full),
        .qctl          (qctl),
        .item          (f_item)
    );

    rpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (qctl.push),
        .push_item (f_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_item)
    );

    rpt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_limit   (limit_reg),
        .cfg_timeout (timeout_reg),
        .q_not_empty (q_not_empty),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .res         (res)
    );

    assign kind           = res.kind;
    assign out_message_id = res.id;
    assign out_link       = res.link;
    assign out_buffer     = res.buffer;
    assign removed_count  = res.count;
    assign last           = res.last;

endmodule

### rtl/core/rpt_checker.sv
// Port-level checks for the retransmit pending table unit, with its bind.
module rpt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  kind,
    input  logic [15:0] out_message_id,
    input  logic [4:0]  removed_count,
    input  logic        last
);
    import rpt_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(kind) && $stable(out_message_id))
        else $error("stalled result changed");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> kind == KIND_DONE)
        else $error("last set on a result that is not done");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DONE |-> last && out_message_id == 16'd0)
        else $error("done result malformed");

    a_count_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DONE |-> removed_count == 5'd0)
        else $error("removed count outside a done result");

endmodule

bind retransmit_pending_table_unit rpt_checker u_rpt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .out_message_id (out_message_id),
    .removed_count  (removed_count),
    .last           (last)
);

### verif/tb_retransmit_pending_table_unit.sv
// Testbench for the retransmit pending table: directed table, random traffic, result checking.
module tb_retransmit_pending_table_unit;
    import rpt_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [2:0] OP_UNUSED6 = 3'd6;
    localparam logic [2:0] OP_UNUSED7 = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [15:0] message_id;
    logic [3:0]  token_length;
    logic [63:0] token_value;
    logic [15:0] link_handle;
    logic [15:0] buffer_handle;
    logic        is_multicast;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  kind;
    logic [15:0] out_message_id;
    logic [15:0] out_link;
    logic [15:0] out_buffer;
    logic [4:0]  removed_count;
    logic        last;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    retransmit_pending_table_unit uut (.*);

    // Predictor state: a shadow copy of the table and both registers.
    rpt_entry_t  shadow_tab [TABLE_ENTRIES];
    int          shadow_count;
    logic [7:0]  shadow_limit;
    logic [15:0] shadow_timeout;

    // Results the table still owes us, oldest first.
    rpt_result_t pending_results [$];
    int          fail_count;
    int          cycle_count;
    bit          no_idle;

    // One row of the directed table. When has_kind is set, the first
    // result of the item is known by inspection and is typed in here.
    typedef struct {
        rpt_item_t  item;
        bit         has_kind;
        logic [3:0] first_kind;
    } directed_row_t;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Cycle counter doubles as the watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void push_result(logic [3:0] k, logic [15:0] id, logic [15:0] lnk,
                                        logic [15:0] buf_h, logic [4:0] cnt, logic lst);
        rpt_result_t r;
        r.kind   = k;
        r.id     = id;
        r.link   = lnk;
        r.buffer = buf_h;
        r.count  = cnt;
        r.last   = lst;
        pending_results.push_back(r);
    endfunction

    // Closes the gap left by a removed entry, keeping insertion order.
    function automatic void drop_slot(int idx);
        for (int j = idx; j + 1 < shadow_count; j++)
            shadow_tab[j] = shadow_tab[j + 1];
        shadow_count--;
    endfunction

    function automatic int find_slot(logic [15:0] id, logic [3:0] len, logic [63:0] tok,
                                     bit use_id);
        for (int i = 0; i < shadow_count; i++)
            if ((!use_id || shadow_tab[i].id == id) && shadow_tab[i].len == len &&
                shadow_tab[i].tok == tok)
                return i;
        return -1;
    endfunction

    // Applies one accepted item to the shadow table and queues its results.
    function automatic void predict_table(rpt_item_t it);
        logic [3:0]  len;
        logic [63:0] tok;
        int          hit;
        int          i;
        int          removed;
        rpt_entry_t  e;
        len = (it.len > TOKEN_BYTES) ? 4'(TOKEN_BYTES) : it.len;
        tok = (len >= 8) ? it.tok : (it.tok & ((64'd1 << (len * 8)) - 64'd1));
        removed = 0;
        case (it.opcode)
            OP_ADD:
            begin
                hit = find_slot(it.id, len, tok, 1'b1);
                if (hit >= 0)
                    push_result(KIND_DUP, shadow_tab[hit].id, shadow_tab[hit].link,
                                shadow_tab[hit].buffer, 5'd0, 1'b0);
                else if (shadow_count >= TABLE_ENTRIES)
                    push_result(KIND_FULL, it.id, it.link, it.buffer, 5'd0, 1'b0);
                else
                begin
                    e.id       = it.id;
                    e.tok      = tok;
                    e.len      = len;
                    e.link     = it.link;
                    e.buffer   = it.buffer;
                    e.attempts = 8'd1;
                    e.limit    = it.mcast ? 8'd1 : shadow_limit;
                    e.timer    = shadow_timeout;
                    shadow_tab[shadow_count] = e;
                    shadow_count++;
                    push_result(KIND_ADDED, it.id, it.link, it.buffer, 5'd0, 1'b0);
                end
            end
            OP_REMOVE, OP_LOOKUP:
            begin
                hit = find_slot(it.id, len, tok, 1'b1);
                if (hit < 0)
                    push_result(KIND_NOTFOUND, it.id, 16'd0, 16'd0, 5'd0, 1'b0);
                else
                begin
                    push_result((it.opcode == OP_REMOVE) ? KIND_REMOVED : KIND_FOUND,
                                shadow_tab[hit].id, shadow_tab[hit].link,
                                shadow_tab[hit].buffer, 5'd0, 1'b0);
                    if (it.opcode == OP_REMOVE)
                        drop_slot(hit);
                end
            end
            OP_REMALL:
            begin
                i = 0;
                while (i < shadow_count)
                begin
                    if (shadow_tab[i].len == len && shadow_tab[i].tok == tok)
                    begin
                        push_result(KIND_REMOVED, shadow_tab[i].id, shadow_tab[i].link,
                                    shadow_tab[i].buffer, 5'd0, 1'b0);
                        removed++;
                        drop_slot(i);
                    end
                    else
                        i++;
                end
                if (removed == 0)
                    push_result(KIND_NOTFOUND, it.id, 16'd0, 16'd0, 5'd0, 1'b0);
            end
            OP_TICK:
            begin
                // A running timer only counts down; one already at zero
                // either resends and reloads, or expires at its limit.
                i = 0;
                while (i < shadow_count)
                begin
                    if (shadow_tab[i].timer != 0)
                    begin
                        shadow_tab[i].timer--;
                        i++;
                    end
                    else if (shadow_tab[i].attempts < shadow_tab[i].limit)
                    begin
                        push_result(KIND_RESEND, shadow_tab[i].id, shadow_tab[i].link,
                                    shadow_tab[i].buffer, 5'd0, 1'b0);
                        shadow_tab[i].timer = shadow_timeout;
                        shadow_tab[i].attempts++;
                        i++;
                    end
                    else
                    begin
                        push_result(KIND_EXPIRED, shadow_tab[i].id, shadow_tab[i].link,
                                    shadow_tab[i].buffer, 5'd0, 1'b0);
                        drop_slot(i);
                    end
                end
            end
            OP_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        push_result(KIND_DONE, 16'd0, 16'd0, 16'd0,
                    (removed > 31) ? 5'd31 : 5'(removed), 1'b1);
    endfunction

    // Mostly short gaps, now and then a long one, none in busy stretches.
    function automatic int idle_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Result side: stall decided at the falling edge, checked at the rising edge.
    int stall_left;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall  = 1'b1;
        end
        else
        begin
            stall_left = idle_gap();
            out_stall  = (stall_left > 0);
            if (stall_left > 0)
                stall_left = stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        rpt_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d id=%h", $time, kind, out_message_id);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind || out_message_id !== want.id ||
                    out_link !== want.link || out_buffer !== want.buffer ||
                    removed_count !== want.count || last !== want.last)
                begin
                    $display("%0t: mismatch expected kind=%0d id=%h link=%h buf=%h cnt=%0d last=%b",
                             $time, want.kind, want.id, want.link, want.buffer, want.count,
                             want.last);
                    $display("%0t:          actual   kind=%0d id=%h link=%h buf=%h cnt=%0d last=%b",
                             $time, kind, out_message_id, out_link, out_buffer, removed_count,
                             last);
                    fail_count++;
                end
            end
        end
    end

    // Presents one item from the falling edge until the table takes it.
    task automatic send_item(rpt_item_t it, bit has_kind, logic [3:0] first_kind);
        int gap;
        int at;
        gap = idle_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid      = 1'b1;
        opcode        = it.opcode;
        message_id    = it.id;
        token_length  = it.len;
        token_value   = it.tok;
        link_handle   = it.link;
        buffer_handle = it.buffer;
        is_multicast  = it.mcast;
        do
            @(posedge clk);
        while (in_stall);
        at = pending_results.size();
        predict_table(it);
        if (has_kind && pending_results[at].kind !== first_kind)
        begin
            $display("%0t: directed row expected kind=%0d actual predicted kind=%0d",
                     $time, first_kind, pending_results[at].kind);
            fail_count++;
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Register writes happen only with the table idle and drained.
    task automatic write_reg(logic [0:0] idx, logic [15:0] value);
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        if (idx == CFG_LIMIT)
            shadow_limit = value[7:0];
        else
            shadow_timeout = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic rpt_item_t make_item(logic [2:0] op, logic [15:0] id, logic [3:0] len,
                                            logic [63:0] tok, logic [15:0] lnk,
                                            logic [15:0] buf_h, logic mc);
        rpt_item_t it;
        it.opcode = op;
        it.id     = id;
        it.len    = len;
        it.tok    = tok;
        it.link   = lnk;
        it.buffer = buf_h;
        it.mcast  = mc;
        return it;
    endfunction

    // Random items draw ids and tokens from small pools so that matches,
    // duplicates and a full table all happen often.
    function automatic rpt_item_t random_item();
        rpt_item_t it;
        int roll;
        roll = $urandom_range(99);
        if (roll < 36)      it.opcode = OP_ADD;
        else if (roll < 46) it.opcode = OP_REMOVE;
        else if (roll < 53) it.opcode = OP_REMALL;
        else if (roll < 65) it.opcode = OP_LOOKUP;
        else if (roll < 94) it.opcode = OP_TICK;
        else if (roll < 96) it.opcode = OP_CLEAR;
        else                it.opcode = $urandom_range(1) ? OP_UNUSED6 : OP_UNUSED7;
        it.id  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(5));
        it.len = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2) * 2);
        if ($urandom_range(5) == 0)
            it.tok = {$urandom, $urandom};
        else
            it.tok = {$urandom_range(1) ? 32'hffff_ffff : 32'h0, 32'($urandom_range(3))};
        it.link   = 16'($urandom);
        it.buffer = 16'($urandom);
        it.mcast  = ($urandom_range(3) == 0);
        return it;
    endfunction

    directed_row_t directed [] = '{
        '{make_item(OP_LOOKUP, 16'h0000, 4'd0, 64'd0, 16'd0, 16'd0, 1'b0), 1'b1, KIND_NOTFOUND},
        '{make_item(OP_REMOVE, 16'hffff, 4'd8, '1, '1, '1, 1'b1), 1'b1, KIND_NOTFOUND},
        '{make_item(OP_REMALL, 16'h1234, 4'd2, 64'hab, 16'd1, 16'd1, 1'b0), 1'b1, KIND_NOTFOUND},
        '{make_item(OP_TICK, 16'd0, 4'd0, 64'd0, 16'd0, 16'd0, 1'b0), 1'b1, KIND_DONE},
        '{make_item(OP_UNUSED6, '1, '1, '1, '1, '1, 1'b1), 1'b1, KIND_DONE},
        '{make_item(OP_UNUSED7, 16'd0, 4'd0, 64'd0, 16'd0, 16'd0, 1'b0), 1'b1, KIND_DONE},
        '{make_item(OP_ADD, 16'h0000, 4'd0, 64'h5555, 16'h0000, 16'h0000, 1'b0), 1'b1, KIND_ADDED},
        '{make_item(OP_ADD, 16'hffff, 4'd8, '1, 16'hffff, 16'hffff, 1'b1), 1'b1, KIND_ADDED},
        // Duplicate id and token: stored fields come back, not the new ones.
        '{make_item(OP_ADD, 16'hffff, 4'd8, '1, 16'h1111, 16'h2222, 1'b0), 1'b1, KIND_DUP},
        // Token length above eight is clipped, so this matches the entry above.
        '{make_item(OP_LOOKUP, 16'hffff, 4'd15, '1, 16'd0, 16'd0, 1'b0), 1'b1, KIND_FOUND},
        '{make_item(OP_ADD, 16'h0042, 4'd2, 64'hdead_beef, 16'h0a0a, 16'h0b0b, 1'b0), 0, 4'd0},
        '{make_item(OP_ADD, 16'h0043, 4'd2, 64'h0000_beef, 16'h0c0c, 16'h0d0d, 1'b1), 0, 4'd0},
        '{make_item(OP_REMALL, 16'd0, 4'd2, 64'hbeef, 16'd0, 16'd0, 1'b0), 0, 4'd0},
        '{make_item(OP_REMOVE, 16'h0000, 4'd0, 64'h0, 16'd0, 16'd0, 1'b0), 1'b1, KIND_REMOVED},
        '{make_item(OP_TICK, 16'd0, 4'd0, 64'd0, 16'd0, 16'd0, 1'b0), 0, 4'd0},
        '{make_item(OP_CLEAR, 16'd0, 4'd0, 64'd0, 16'd0, 16'd0, 1'b0), 1'b1, KIND_DONE},
        '{make_item(OP_LOOKUP, 16'hffff, 4'd8, '1, 16'd0, 16'd0, 1'b0), 1'b1, KIND_NOTFOUND}
    };

    initial
    begin
        logic [7:0]  limits   [5];
        logic [15:0] timeouts [5];
        rpt_item_t   it;

        limits        = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd3};
        timeouts      = '{16'd0, 16'd65535, 16'd0, 16'd1, 16'd3};
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        opcode        = OP_ADD;
        message_id    = '0;
        token_length  = '0;
        token_value   = '0;
        link_handle   = '0;
        buffer_handle = '0;
        is_multicast  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_LIMIT;
        cfg_data      = '0;
        fail_count    = 0;
        cycle_count   = 0;
        stall_left    = 0;
        no_idle       = 1'b0;
        shadow_count  = 0;
        shadow_limit  = 8'd4;
        shadow_timeout = 16'd2000;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[r])
            send_item(directed[r].item, directed[r].has_kind, directed[r].first_kind);

        // Each phase sets both registers, then runs random traffic. Timeout
        // zero and limit zero make entries fire or expire on the next tick.
        for (int p = 0; p < 5; p++)
        begin
            write_reg(CFG_LIMIT, {8'd0, limits[p]});
            write_reg(CFG_TIMEOUT, timeouts[p]);
            for (int k = 0; k < 80; k++)
            begin
                no_idle = (k >= 30 && k < 45);
                it = random_item();
                send_item(it, 1'b0, 4'd0);
                // Hold off now and then until the table has answered everything.
                if (k == 60)
                    wait (pending_results.size() == 0);
            end
            no_idle = 1'b0;
        end

        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
